### hw/rtl/ohsp_pkg.sv
// OBEX header stream parser: shared types and constants.
// Used by every module of the parser; depends on nothing.
`default_nettype none

package ohsp_pkg;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned S_TUSER_W = 1;
    localparam int unsigned M_TDATA_W = DATA_W + VALUE_W;
    localparam int unsigned M_TUSER_W = KIND_W + 1;

    localparam logic [DATA_W-1:0] TYPE_MASK     = 8'hC0;
    localparam logic [DATA_W-1:0] TYPE_UNICODE  = 8'h00;
    localparam logic [DATA_W-1:0] TYPE_BYTESEQ  = 8'h40;
    localparam logic [DATA_W-1:0] TYPE_ONE_BYTE = 8'h80;
    localparam logic [DATA_W-1:0] TYPE_FOUR     = 8'hC0;
    localparam logic [LEN_W-1:0]  LEN_OVERHEAD  = 16'd3;

    typedef enum logic [2:0] {
        PH_ID      = 3'd0,
        PH_BYTE    = 3'd1,
        PH_FOUR    = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_LEN_LO  = 3'd4,
        PH_PAYLOAD = 3'd5
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE    = 2'd0,
        KIND_FOUR    = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_EMPTY   = 2'd3
    } kind_t;

    // one input beat held in the input register
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              restart;
    } in_beat_t;

    // one result item
    typedef struct packed {
        logic [DATA_W-1:0]  header_id;
        kind_t              result_kind;
        logic [VALUE_W-1:0] value;
        logic               last_of_header;
        logic               length_error;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/obex_header_stream_parser.sv
// OBEX header stream parser, top level: one header byte per beat in, at most one result out.
// A byte is decoded from the input register; its result goes into the result register.
// Throughput: one byte per cycle; the input register, decode step and result register
// each move one beat a cycle, held back only while the master side stalls a waiting result.
// Reset (rst_n, asynchronous, active low) empties both registers and returns the parser
// to expecting an identifier byte. Depends on ohsp_pkg and the three ohsp_* stages.
`default_nettype none

module obex_header_stream_parser
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // slave side
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [ohsp_pkg::DATA_W-1:0]      s_tdata,  // [7:0] data_byte
    input  wire logic [ohsp_pkg::S_TUSER_W-1:0]   s_tuser,  // [0] restart
    // master side
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [ohsp_pkg::M_TDATA_W-1:0]        m_tdata,  // [7:0] header_id, [39:8] value
    output logic [ohsp_pkg::M_TUSER_W-1:0]        m_tuser,  // [1:0] result_kind, [2] length_error
    output logic                                  m_tlast   // last_of_header
);

    ohsp_pkg::in_beat_t s_beat;
    ohsp_pkg::in_beat_t beat;
    ohsp_pkg::result_t  result;
    ohsp_pkg::result_t  held;
    logic               beat_valid;
    logic               out_free;
    logic               step;
    logic               emit;

    assign s_beat.data_byte = s_tdata;
    assign s_beat.restart   = s_tuser[0];

    // a held beat is decoded as soon as the result register has room for its result
    assign step = beat_valid && out_free;

    ohsp_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_beat     (s_beat),
        .consume    (step),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    ohsp_parse_core u_parse_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .beat   (beat),
        .emit   (emit),
        .result (result)
    );

    ohsp_out_stage u_out_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .emit     (emit),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .held     (held)
    );

    // pack the held result onto the master side
    assign m_tdata = {held.value, held.header_id};
    assign m_tuser = {held.length_error, held.result_kind};
    assign m_tlast = held.last_of_header;

endmodule

`default_nettype wire

### hw/rtl/ohsp_in_stage.sv
// Input register of the parser: captures one beat from the slave side.
// Depends on ohsp_pkg.
`default_nettype none

module ohsp_in_stage
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire ohsp_pkg::in_beat_t s_beat,
    input  wire logic              consume,   // parser takes the held beat
    output logic                   beat_valid,
    output ohsp_pkg::in_beat_t     beat
);

    logic               valid_reg;
    logic               valid_next;
    ohsp_pkg::in_beat_t beat_reg;

    assign s_tready   = !valid_reg || consume;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            beat_reg <= s_beat;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ohsp_parse_core.sv
// Parser state and per-byte decode: phase, identifier, value and length counters.
// Depends on ohsp_pkg.
`default_nettype none

module ohsp_parse_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,      // apply the beat this cycle
    input  wire ohsp_pkg::in_beat_t beat,
    output logic                    emit,
    output ohsp_pkg::result_t       result
);

    ohsp_pkg::phase_t                phase_reg, phase_next, phase_eff;
    logic [ohsp_pkg::DATA_W-1:0]     id_reg, id_next;
    logic [ohsp_pkg::VALUE_W-1:0]    acc_reg, acc_next;
    logic [1:0]                      left_reg, left_next;
    logic [ohsp_pkg::LEN_W-1:0]      rem_reg, rem_next;
    logic [ohsp_pkg::LEN_W-1:0]      len;
    logic [ohsp_pkg::LEN_W-1:0]      rem_dec;
    logic [ohsp_pkg::VALUE_W-1:0]    acc_shift;
    logic [ohsp_pkg::DATA_W-1:0]     id_type;
    logic [ohsp_pkg::VALUE_W-1:0]    byte_ext;

    always_comb
    begin
        phase_eff  = beat.restart ? ohsp_pkg::PH_ID : phase_reg;
        len        = {rem_reg[ohsp_pkg::LEN_W-1:ohsp_pkg::DATA_W], beat.data_byte};
        rem_dec    = rem_reg - ohsp_pkg::LEN_W'(1);
        acc_shift  = {acc_reg[ohsp_pkg::VALUE_W-ohsp_pkg::DATA_W-1:0], beat.data_byte};
        id_type    = beat.data_byte & ohsp_pkg::TYPE_MASK;
        byte_ext   = ohsp_pkg::VALUE_W'(beat.data_byte);

        phase_next = phase_reg;
        id_next    = id_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        rem_next   = rem_reg;

        emit                  = 1'b0;
        result.header_id      = id_reg;
        result.result_kind    = ohsp_pkg::KIND_BYTE;
        result.value          = byte_ext;
        result.last_of_header = 1'b1;
        result.length_error   = 1'b0;

        case (phase_eff)
            ohsp_pkg::PH_BYTE:
            begin
                phase_next = ohsp_pkg::PH_ID;
                emit       = 1'b1;
            end
            ohsp_pkg::PH_FOUR:
            begin
                acc_next = acc_shift;
                if (left_reg == 2'd0)
                begin
                    phase_next         = ohsp_pkg::PH_ID;
                    emit               = 1'b1;
                    result.result_kind = ohsp_pkg::KIND_FOUR;
                    result.value       = acc_shift;
                end
                else
                begin
                    left_next = left_reg - 2'd1;
                end
            end
            ohsp_pkg::PH_LEN_HI:
            begin
                rem_next   = {beat.data_byte, ohsp_pkg::DATA_W'(0)};
                phase_next = ohsp_pkg::PH_LEN_LO;
            end
            ohsp_pkg::PH_LEN_LO:
            begin
                if (len <= ohsp_pkg::LEN_OVERHEAD)
                begin
                    rem_next            = '0;
                    phase_next          = ohsp_pkg::PH_ID;
                    emit                = 1'b1;
                    result.result_kind  = ohsp_pkg::KIND_EMPTY;
                    result.value        = '0;
                    result.length_error = (len < ohsp_pkg::LEN_OVERHEAD);
                end
                else
                begin
                    rem_next   = len - ohsp_pkg::LEN_OVERHEAD;
                    phase_next = ohsp_pkg::PH_PAYLOAD;
                end
            end
            ohsp_pkg::PH_PAYLOAD:
            begin
                rem_next              = rem_dec;
                emit                  = 1'b1;
                result.result_kind    = ohsp_pkg::KIND_PAYLOAD;
                result.last_of_header = (rem_dec == '0);
                if (rem_dec == '0)
                begin
                    phase_next = ohsp_pkg::PH_ID;
                end
            end
            default:
            begin
                // identifier byte; unused phase codes land here too
                id_next   = beat.data_byte;
                acc_next  = '0;
                left_next = 2'd0;
                rem_next  = '0;
                if (id_type == ohsp_pkg::TYPE_ONE_BYTE)
                begin
                    phase_next = ohsp_pkg::PH_BYTE;
                end
                else if (id_type == ohsp_pkg::TYPE_FOUR)
                begin
                    left_next  = 2'd3;
                    phase_next = ohsp_pkg::PH_FOUR;
                end
                else
                begin
                    phase_next = ohsp_pkg::PH_LEN_HI;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ohsp_pkg::PH_ID;
            id_reg    <= '0;
            acc_reg   <= '0;
            left_reg  <= '0;
            rem_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            id_reg    <= id_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ohsp_out_stage.sv
// Result register of the parser: holds one result until the master side takes it.
// Depends on ohsp_pkg.
`default_nettype none

module ohsp_out_stage
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,      // parser step this cycle
    input  wire logic              emit,      // step produced a result
    input  wire ohsp_pkg::result_t result,
    output logic                   free,      // register can take a result now
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output ohsp_pkg::result_t      held
);

    logic              valid_reg;
    logic              valid_next;
    ohsp_pkg::result_t result_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign held     = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = emit;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && emit)
        begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

### verif/tb_obex_header_stream_parser.sv
// Self-checking bench for obex_header_stream_parser: directed table, then random header streams.
// Expected results come from given table rows, else from a behavioural parser model in the bench.
// Depends on ohsp_pkg and the parser RTL only.
`timescale 1ns / 100ps

module tb_obex_header_stream_parser;

    localparam int RAND_ITEMS = 700;
    localparam int IDLE_LIMIT = 2000;   // cycles with no beat moving on either side
    localparam int DRAIN_WAIT = 6;      // result register sits behind its byte's input register

    localparam ohsp_pkg::result_t NO_RES = '0;

    // one beat of stimulus; rows with 'given' set carry a hand-written expected result
    typedef struct {
        logic [7:0]        data_byte;
        logic              restart;
        bit                given;
        ohsp_pkg::result_t res;
    } stim_beat_t;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic              restart;
        logic              given;
        ohsp_pkg::result_t res;
    } dir_row_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_BLOCKY
    } rx_mode_t;

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [ohsp_pkg::DATA_W-1:0]      s_tdata;    // [7:0] data_byte
    logic [ohsp_pkg::S_TUSER_W-1:0]   s_tuser;    // [0] restart
    logic                             m_tvalid;
    logic                             m_tready;
    logic [ohsp_pkg::M_TDATA_W-1:0]   m_tdata;    // [7:0] header_id, [39:8] value
    logic [ohsp_pkg::M_TUSER_W-1:0]   m_tuser;    // [1:0] result_kind, [2] length_error
    logic                             m_tlast;    // last_of_header

    obex_header_stream_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Directed part: extremes of each header type, short and exact lengths,
    // a short payload and a restart that cuts a four-byte header short.
    dir_row_t dir_tab [24] = '{
        '{8'h80, 1'b0, 1'b0, NO_RES},                                   // one-byte id
        '{8'h00, 1'b0, 1'b1, '{8'h80, ohsp_pkg::KIND_BYTE, 32'h0, 1'b1, 1'b0}},
        '{8'hBF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b1, '{8'hBF, ohsp_pkg::KIND_BYTE, 32'hFF, 1'b1, 1'b0}},
        '{8'hC0, 1'b0, 1'b0, NO_RES},                                   // four-byte id
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b1, '{8'hC0, ohsp_pkg::KIND_FOUR, 32'hFFFF_FFFF, 1'b1, 1'b0}},
        '{8'h01, 1'b0, 1'b0, NO_RES},                                   // unicode, length 0
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b1, '{8'h01, ohsp_pkg::KIND_EMPTY, 32'h0, 1'b1, 1'b1}},
        '{8'h7F, 1'b0, 1'b0, NO_RES},                                   // byte seq, length 3
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h03, 1'b0, 1'b1, '{8'h7F, ohsp_pkg::KIND_EMPTY, 32'h0, 1'b1, 1'b0}},
        '{8'h41, 1'b0, 1'b0, NO_RES},                                   // two payload bytes
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h05, 1'b0, 1'b0, NO_RES},
        '{8'hAA, 1'b0, 1'b0, NO_RES},
        '{8'h55, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},                                   // four-byte, cut short
        '{8'h12, 1'b0, 1'b0, NO_RES},
        '{8'h80, 1'b1, 1'b0, NO_RES},                                   // restart mid-header
        '{8'h7E, 1'b0, 1'b1, '{8'h80, ohsp_pkg::KIND_BYTE, 32'h7E, 1'b1, 1'b0}}
    };

    stim_beat_t        stim_q [$];
    ohsp_pkg::result_t expected_results [$];

    // parser model state
    ohsp_pkg::phase_t hdr_phase;
    logic [7:0]       hdr_id;
    logic [31:0]      acc_value;
    logic [1:0]       four_left;
    logic [15:0]      pay_left;

    int                drv_idx;
    int                burst_left;
    int                gap_left;
    int                acc_idx;
    int                idle_cnt;
    int                errs;
    int                rx_cnt;
    int                mode_left;
    rx_mode_t          rx_mode;
    ohsp_pkg::result_t mon_want;
    ohsp_pkg::result_t mon_pred;
    bit                mon_got;

    // Model of the parser: one byte in, at most one result out.
    task automatic parse_byte(input logic [7:0] b, input logic rs,
                              output bit got, output ohsp_pkg::result_t r);
        ohsp_pkg::phase_t ph;
        logic [15:0]      len;
        begin
            got = 1'b0;
            r   = NO_RES;
            r.header_id = hdr_id;
            ph = rs ? ohsp_pkg::PH_ID : hdr_phase;
            case (ph)
                ohsp_pkg::PH_BYTE:
                begin
                    hdr_phase        = ohsp_pkg::PH_ID;
                    got              = 1'b1;
                    r.result_kind    = ohsp_pkg::KIND_BYTE;
                    r.value          = {24'd0, b};
                    r.last_of_header = 1'b1;
                end
                ohsp_pkg::PH_FOUR:
                begin
                    acc_value = {acc_value[23:0], b};
                    if (four_left == 2'd0)
                    begin
                        hdr_phase        = ohsp_pkg::PH_ID;
                        got              = 1'b1;
                        r.result_kind    = ohsp_pkg::KIND_FOUR;
                        r.value          = acc_value;
                        r.last_of_header = 1'b1;
                    end
                    else
                    begin
                        four_left = four_left - 2'd1;
                    end
                end
                ohsp_pkg::PH_LEN_HI:
                begin
                    pay_left  = {b, 8'h00};
                    hdr_phase = ohsp_pkg::PH_LEN_LO;
                end
                ohsp_pkg::PH_LEN_LO:
                begin
                    len = {pay_left[15:8], b};
                    if (len <= ohsp_pkg::LEN_OVERHEAD)
                    begin
                        // no payload: one empty result, flagged if the length was short
                        pay_left         = '0;
                        hdr_phase        = ohsp_pkg::PH_ID;
                        got              = 1'b1;
                        r.result_kind    = ohsp_pkg::KIND_EMPTY;
                        r.last_of_header = 1'b1;
                        r.length_error   = (len < ohsp_pkg::LEN_OVERHEAD);
                    end
                    else
                    begin
                        pay_left  = len - ohsp_pkg::LEN_OVERHEAD;
                        hdr_phase = ohsp_pkg::PH_PAYLOAD;
                    end
                end
                ohsp_pkg::PH_PAYLOAD:
                begin
                    pay_left = pay_left - 16'd1;
                    got              = 1'b1;
                    r.result_kind    = ohsp_pkg::KIND_PAYLOAD;
                    r.value          = {24'd0, b};
                    r.last_of_header = (pay_left == 16'd0);
                    if (pay_left == 16'd0)
                        hdr_phase = ohsp_pkg::PH_ID;
                end
                default:
                begin
                    // identifier byte: top two bits pick the header type
                    hdr_id    = b;
                    acc_value = '0;
                    four_left = '0;
                    pay_left  = '0;
                    case (b & ohsp_pkg::TYPE_MASK)
                        ohsp_pkg::TYPE_ONE_BYTE: hdr_phase = ohsp_pkg::PH_BYTE;
                        ohsp_pkg::TYPE_FOUR:
                        begin
                            four_left = 2'd3;
                            hdr_phase = ohsp_pkg::PH_FOUR;
                        end
                        default:                 hdr_phase = ohsp_pkg::PH_LEN_HI;
                    endcase
                end
            endcase
        end
    endtask

    task automatic add_beat(input logic [7:0] b, input logic rs);
        stim_beat_t s;
        begin
            s.data_byte = b;
            s.restart   = rs;
            s.given     = 1'b0;
            s.res       = NO_RES;
            stim_q.push_back(s);
        end
    endtask

    // Random part: mostly well-formed headers with random content, the rest
    // truncated headers and loose bytes. After any of those the next header
    // starts with restart so that it parses from its identifier.
    task automatic build_random();
        int         n;
        int         sel;
        int         len;
        int         k;
        logic [7:0] id;
        logic       need_rs;
        begin
            n       = 0;
            need_rs = 1'b0;
            while (n < RAND_ITEMS)
            begin
                sel = $urandom_range(0, 99);
                id  = 8'($urandom_range(0, 255));
                if (sel < 88)
                begin
                    add_beat(id, need_rs ? 1'b1 : ($urandom_range(0, 3) == 0));
                    n++;
                    need_rs = 1'b0;
                    case (id & ohsp_pkg::TYPE_MASK)
                        ohsp_pkg::TYPE_ONE_BYTE:
                        begin
                            add_beat(8'($urandom_range(0, 255)), 1'b0);
                            n++;
                        end
                        ohsp_pkg::TYPE_FOUR:
                        begin
                            for (k = 0; k < 4; k++)
                                add_beat(8'($urandom_range(0, 255)), 1'b0);
                            n += 4;
                        end
                        default:
                        begin
                            k = $urandom_range(0, 99);
                            if (k < 8)
                                len = $urandom_range(0, 2);
                            else if (k < 16)
                                len = 3;
                            else if (k < 19)
                                len = $urandom_range(256, 600);
                            else
                                len = $urandom_range(4, 30);
                            add_beat(len[15:8], 1'b0);
                            add_beat(len[7:0], 1'b0);
                            n += 2;
                            for (k = 0; k < len - 3; k++)
                            begin
                                add_beat(8'($urandom_range(0, 255)), 1'b0);
                                n++;
                            end
                        end
                    endcase
                end
                else if (sel < 95)
                begin
                    add_beat(id, need_rs ? 1'b1 : ($urandom_range(0, 1) == 1));
                    n++;
                    for (k = $urandom_range(0, 3); k > 0; k--)
                    begin
                        add_beat(8'($urandom_range(0, 255)), 1'b0);
                        n++;
                    end
                    need_rs = 1'b1;
                end
                else
                begin
                    add_beat(id, ($urandom_range(0, 1) == 1));
                    n++;
                    need_rs = 1'b1;
                end
            end
            // largest declared length, cut short by a restart, then a closing one-byte header
            add_beat({2'b01, 6'($urandom_range(0, 63))}, 1'b1);
            add_beat(8'hFF, 1'b0);
            add_beat(8'hFF, 1'b0);
            for (k = 0; k < 8; k++)
                add_beat(8'($urandom_range(0, 255)), 1'b0);
            add_beat(8'h80, 1'b1);
            add_beat(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        begin
            if (want !== seen)
            begin
                $error("%s: expected %0h, got %0h", name, want, seen);
                errs++;
            end
        end
    endtask

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Sender: bursts of random length with random gaps; a beat holds until taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                drv_idx++;
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (drv_idx < stim_q.size())
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= stim_q[drv_idx].data_byte;
                    s_tuser  <= stim_q[drv_idx].restart;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: picks a new random stall pattern whenever its mode counter runs out.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_cnt++;
            if (mode_left == 0)
            begin
                rx_mode   <= rx_mode_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(32, 256);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: m_tready <= (rx_cnt % 4 == 0);
                default:   m_tready <= (rx_cnt % 16 >= 10);    // ready only while rx_cnt % 16 is 10 or more
            endcase
        end
    end

    // Checker: results against the oldest expectation, then predict from the
    // beat taken at this edge. Output first, since a result is never caused
    // by the beat accepted at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: header_id %0h kind %0h value %0h",
                           m_tdata[7:0], m_tuser[1:0], m_tdata[39:8]);
                    errs++;
                end
                else
                begin
                    mon_want = expected_results.pop_front();
                    check_field("header_id", 32'(mon_want.header_id), 32'(m_tdata[7:0]));
                    check_field("result_kind", 32'(mon_want.result_kind),
                                32'(m_tuser[1:0]));
                    check_field("value", mon_want.value, m_tdata[39:8]);
                    check_field("last_of_header", 32'(mon_want.last_of_header),
                                32'(m_tlast));
                    check_field("length_error", 32'(mon_want.length_error),
                                32'(m_tuser[2]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                parse_byte(stim_q[acc_idx].data_byte, stim_q[acc_idx].restart,
                           mon_got, mon_pred);
                if (stim_q[acc_idx].given)
                    expected_results.push_back(stim_q[acc_idx].res);
                else if (mon_got)
                    expected_results.push_back(mon_pred);
                acc_idx++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        stim_beat_t s;
        clk        = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        hdr_phase  = ohsp_pkg::PH_ID;
        hdr_id     = '0;
        acc_value  = '0;
        four_left  = '0;
        pay_left   = '0;
        drv_idx    = 0;
        burst_left = 0;
        gap_left   = 0;
        acc_idx    = 0;
        idle_cnt   = 0;
        errs       = 0;
        rx_cnt     = 0;
        mode_left  = 0;
        rx_mode    = RX_OPEN;

        foreach (dir_tab[i])
        begin
            s.data_byte = dir_tab[i].data_byte;
            s.restart   = dir_tab[i].restart;
            s.given     = dir_tab[i].given;
            s.res       = dir_tab[i].res;
            stim_q.push_back(s);
        end
        build_random();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (acc_idx < stim_q.size())
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            errs++;
        end
        if (errs == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
